>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the remote frame transmitter.
// Each macro wraps one concurrent assertion clocked on clk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define RFRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at the same edge.
`define RFRT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/rfrt_pkg.sv
// Package for the remote frame transmitter: payload types, register map,
// phase codes, reset values and the byte-to-symbol helper.
`default_nettype none

package rfrt_pkg;

  // Default sizes.
  localparam int SYNC_ZEROS_DEF       = 12;
  localparam int TICK_COUNT_WIDTH_DEF = 16;

  // Symbols after the sync zeros: sync one, five bytes with parity, trailing zero.
  localparam int FRAME_OVERHEAD = 47;

  // Configuration register map.
  localparam int          CFG_INDEX_W   = 2;
  localparam int          CFG_DATA_W    = 16;
  localparam logic [1:0]  REG_ZERO_HALF = 2'd0;
  localparam logic [1:0]  REG_ONE_HALF  = 2'd1;
  localparam logic [1:0]  REG_GAP       = 2'd2;
  localparam logic [1:0]  REG_REPEAT    = 2'd3;

  // Register reset values.
  localparam logic [15:0] ZERO_HALF_RST = 16'd400;
  localparam logic [15:0] ONE_HALF_RST  = 16'd600;
  localparam logic [15:0] GAP_RST       = 16'd10000;
  localparam logic [2:0]  REPEAT_RST    = 3'd3;

  // Symbol phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_GAP  = 2'd3;

  // Command codes.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Checksum seed.
  localparam logic [7:0] CHECKSUM_SEED = 8'd6;

  typedef struct packed {
    logic        command;
    logic [15:0] house_code;
    logic [7:0]  device_address;
    logic [7:0]  action_code;
  } rfrt_in_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic start_taken;
  } rfrt_out_t;

  typedef struct packed {
    logic [15:0] zero_half_ticks;
    logic [15:0] one_half_ticks;
    logic [15:0] gap_ticks;
    logic [2:0]  repeat_count;
  } rfrt_cfg_t;

  // Nine symbols of one byte in send order (first sent at bit 0):
  // MSB first, then the even parity bit.
  function automatic logic [8:0] byte_symbols(input logic [7:0] b);
    logic [8:0] s;
    for (int k = 0; k < 8; k++) begin
      s[k] = b[7-k];
    end
    s[8] = ^b;
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rf_remote_frame_transmitter.sv
// Remote frame transmitter. Every beat on the input channel is either one
// time tick or a start command; every beat gives exactly one result beat
// with the line level, the busy flag and whether a start was taken. One
// beat is accepted per clock while in_stall is low: the sequencer updates its
// phase, counter and frame rotator in the cycle a beat is taken, the result
// is registered in the output register, and a one-entry skid lets one more
// beat in while that result is stalled (in_stall rises only when both hold a
// result). Configuration writes are taken in any cycle (cfg_ready is always
// high) and act from the next beat on.
// Depends on rfrt_pkg, rfrt_frame_build, rfrt_sequencer, rfrt_out_stage.
`default_nettype none

`include "assert_macros.svh"

module rf_remote_frame_transmitter
  import rfrt_pkg::*;
#(
  parameter int SYNC_ZEROS       = SYNC_ZEROS_DEF,
  parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire rfrt_in_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output rfrt_out_t                   out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int FRAME_LEN = SYNC_ZEROS + FRAME_OVERHEAD;

  rfrt_cfg_t            cfg;
  logic                 in_fire;
  logic [FRAME_LEN-1:0] frame;
  rfrt_out_t            result;
  logic                 skid_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_full;
  assign in_fire   = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_half_ticks <= ZERO_HALF_RST;
      cfg.one_half_ticks  <= ONE_HALF_RST;
      cfg.gap_ticks       <= GAP_RST;
      cfg.repeat_count    <= REPEAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ZERO_HALF: cfg.zero_half_ticks <= cfg_data;
        REG_ONE_HALF:  cfg.one_half_ticks  <= cfg_data;
        REG_GAP:       cfg.gap_ticks       <= cfg_data;
        REG_REPEAT:    cfg.repeat_count    <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Frame symbols from the start beat's fields.
  rfrt_frame_build #(
    .SYNC_ZEROS (SYNC_ZEROS)
  ) u_frame_build (
    .house_code     (in_data.house_code),
    .device_address (in_data.device_address),
    .action_code    (in_data.action_code),
    .frame          (frame)
  );

  // Phase and tick sequencing.
  rfrt_sequencer #(
    .SYNC_ZEROS       (SYNC_ZEROS),
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_sequencer (
    .clk       (clk),
    .rst       (rst),
    .item_fire (in_fire),
    .command   (in_data.command),
    .frame     (frame),
    .cfg       (cfg),
    .result    (result)
  );

  // Result register and skid.
  rfrt_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_result (result),
    .skid_full (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The skid only fills behind a held output result.
  `RFRT_ASSERT_IMPL(a_skid_behind_out, in_stall, out_valid, "skid full with empty output register")
  // The input side stalls only after the output side was stalled with a result.
  `RFRT_ASSERT_IMPL(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall), "input stall without output stall")
  // A taken start always reports a busy line driven high.
  `RFRT_ASSERT_IMPL(a_start_result, out_valid && out_data.start_taken, out_data.busy_res && out_data.pin_level, "start result not busy and high")

endmodule

`default_nettype wire

>>> rtl/rfrt_frame_build.sv
// Frame assembly: checksum, parity and symbol ordering of one frame.
// Depends on rfrt_pkg.
`default_nettype none

module rfrt_frame_build
  import rfrt_pkg::*;
#(
  parameter int SYNC_ZEROS = SYNC_ZEROS_DEF
) (
  input  wire logic [15:0]                       house_code,
  input  wire logic [7:0]                        device_address,
  input  wire logic [7:0]                        action_code,
  output logic      [SYNC_ZEROS+FRAME_OVERHEAD-1:0] frame
);

  logic [7:0] hc_hi;
  logic [7:0] hc_lo;
  logic [7:0] checksum;

  // Checksum is the seed plus the four payload bytes, modulo 256.
  assign hc_hi    = house_code[15:8];
  assign hc_lo    = house_code[7:0];
  assign checksum = CHECKSUM_SEED + hc_hi + hc_lo + device_address + action_code;

  // Symbol i of the frame sits at bit i; the trailing zero is the top bit.
  assign frame = {1'b0,
                  byte_symbols(checksum),
                  byte_symbols(action_code),
                  byte_symbols(device_address),
                  byte_symbols(hc_lo),
                  byte_symbols(hc_hi),
                  1'b1,
                  {SYNC_ZEROS{1'b0}}};

endmodule

`default_nettype wire

>>> rtl/rfrt_sequencer.sv
// Symbol sequencer: phase state, tick counter, frame rotator and repeat count.
// Depends on rfrt_pkg; the frame comes from rfrt_frame_build.
`default_nettype none

module rfrt_sequencer
  import rfrt_pkg::*;
#(
  parameter int SYNC_ZEROS       = SYNC_ZEROS_DEF,
  parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  item_fire,
  input  wire logic                                  command,
  input  wire logic [SYNC_ZEROS+FRAME_OVERHEAD-1:0]  frame,
  input  wire rfrt_cfg_t                             cfg,
  output rfrt_out_t                                  result
);

  localparam int FRAME_LEN = SYNC_ZEROS + FRAME_OVERHEAD;
  localparam int IDX_W     = $clog2(FRAME_LEN + 1);
  localparam int TCW       = TICK_COUNT_WIDTH;
  localparam int CMP_W     = (TCW > 16) ? TCW : 16;
  localparam logic [TCW-1:0] COUNT_MAX = {TCW{1'b1}};

  logic [1:0]           phase;
  logic [1:0]           phase_next;
  logic [FRAME_LEN-1:0] frame_bits;
  logic [FRAME_LEN-1:0] frame_bits_next;
  logic [IDX_W-1:0]     symbol_index;
  logic [IDX_W-1:0]     symbol_index_next;
  logic [2:0]           repeats_left;
  logic [2:0]           repeats_left_next;
  logic [TCW-1:0]       tick_counter;
  logic [TCW-1:0]       tick_counter_next;

  logic [15:0]      len_sel;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] limit;
  logic [TCW-1:0]   cnt_inc;
  logic             done;
  logic [IDX_W-1:0] idx_inc;
  logic             last_symbol;
  logic [2:0]       rep_dec;

  // Length of the current phase, clipped to what the counter can hold.
  assign len_sel = (phase == PH_GAP) ? cfg.gap_ticks :
                   (frame_bits[0] ? cfg.one_half_ticks : cfg.zero_half_ticks);
  assign len_ext = CMP_W'(len_sel);
  assign limit   = (len_ext > CMP_W'(COUNT_MAX)) ? CMP_W'(COUNT_MAX) : len_ext;

  // Saturating tick count and phase completion.
  assign cnt_inc     = (tick_counter == COUNT_MAX) ? tick_counter : tick_counter + 1'b1;
  assign done        = CMP_W'(cnt_inc) >= limit;
  assign idx_inc     = symbol_index + 1'b1;
  assign last_symbol = (idx_inc == IDX_W'(FRAME_LEN));
  assign rep_dec     = repeats_left - 3'd1;

  // Next state and the result of the beat being taken.
  always_comb begin
    phase_next        = phase;
    frame_bits_next   = frame_bits;
    symbol_index_next = symbol_index;
    repeats_left_next = repeats_left;
    tick_counter_next = tick_counter;
    result            = '0;

    if (item_fire) begin
      if (command == CMD_START) begin
        if (phase == PH_IDLE) begin
          frame_bits_next   = frame;
          symbol_index_next = '0;
          tick_counter_next = '0;
          repeats_left_next = (cfg.repeat_count == 3'd0) ? 3'd1 : cfg.repeat_count;
          phase_next        = PH_HIGH;
          result.start_taken = 1'b1;
          result.busy_res    = 1'b1;
          result.pin_level   = 1'b1;
        end else begin
          result.busy_res  = 1'b1;
          result.pin_level = (phase == PH_HIGH);
        end
      end else begin
        result.busy_res = (phase != PH_IDLE);
        case (phase)
          PH_HIGH: begin
            result.pin_level = 1'b1;
            if (done) begin
              tick_counter_next = '0;
              phase_next        = PH_LOW;
            end else begin
              tick_counter_next = cnt_inc;
            end
          end
          PH_LOW: begin
            if (done) begin
              tick_counter_next = '0;
              // Rotate so the next symbol sits at bit 0; a full pass restores the frame.
              frame_bits_next   = {frame_bits[0], frame_bits[FRAME_LEN-1:1]};
              symbol_index_next = idx_inc;
              if (last_symbol) begin
                if (cfg.gap_ticks == 16'd0) begin
                  repeats_left_next = rep_dec;
                  symbol_index_next = '0;
                  phase_next        = (rep_dec == 3'd0) ? PH_IDLE : PH_HIGH;
                end else begin
                  phase_next = PH_GAP;
                end
              end else begin
                phase_next = PH_HIGH;
              end
            end else begin
              tick_counter_next = cnt_inc;
            end
          end
          PH_GAP: begin
            if (done) begin
              tick_counter_next = '0;
              repeats_left_next = rep_dec;
              symbol_index_next = '0;
              phase_next        = (rep_dec == 3'd0) ? PH_IDLE : PH_HIGH;
            end else begin
              tick_counter_next = cnt_inc;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      frame_bits   <= '0;
      symbol_index <= '0;
      repeats_left <= 3'd0;
      tick_counter <= '0;
    end else begin
      phase        <= phase_next;
      frame_bits   <= frame_bits_next;
      symbol_index <= symbol_index_next;
      repeats_left <= repeats_left_next;
      tick_counter <= tick_counter_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rfrt_out_stage.sv
// Output register with a one-entry skid buffer, so a result can wait while
// the next beat is still taken. Depends on rfrt_pkg.
`default_nettype none

module rfrt_out_stage
  import rfrt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_fire,
  input  wire rfrt_out_t in_result,
  output logic           skid_full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output rfrt_out_t      out_data
);

  logic      skid_valid;
  rfrt_out_t skid_data;
  logic      out_fire;

  assign out_fire  = out_valid && !out_stall;
  assign skid_full = skid_valid;

  // Control: the skid holds a result only while the output register is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid && !out_fire) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (in_fire) begin
      if (out_valid && !out_fire) begin
        skid_data <= in_result;
      end else begin
        out_data <= in_result;
      end
    end
  end

endmodule

`default_nettype wire

>>> test/rf_remote_frame_transmitter_tb.sv
// Self-checking testbench for rf_remote_frame_transmitter: random ticks and starts
// against a built-in line predictor, with random pacing and register phases.
// Depends on rfrt_pkg and the transmitter RTL only.
`timescale 1ns / 100ps

module rf_remote_frame_transmitter_tb;
  import rfrt_pkg::*;

  localparam int FRAME_SYMS  = SYNC_ZEROS_DEF + FRAME_OVERHEAD;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_BEATS = 900;

  typedef enum logic [1:0] {SEND_BEAT, SEND_REG, WAIT_QUIET} feed_kind_t;

  typedef struct {
    feed_kind_t              kind;
    rfrt_in_t                beat;
    logic [CFG_INDEX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0]   reg_value;
    int                      gap;
  } feed_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  rfrt_in_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  rfrt_out_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Stimulus feed, expected line levels and bookkeeping.
  feed_entry_t feed_q[$];
  rfrt_out_t   levels_due[$];
  rfrt_out_t   due_level = '0;
  logic        due_valid = 1'b0;
  logic        feed_done = 1'b0;
  int          results_seen = 0;
  int          beats_taken = 0;
  int          send_idle = 0;
  int          tx_style = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  // Predictor copy of the registers and the transmit state.
  logic [15:0] zero_half;
  logic [15:0] one_half;
  logic [15:0] gap_len;
  logic [2:0]  rep_count;
  logic [63:0] frame_syms;
  logic [5:0]  sym_pos;
  logic [2:0]  reps_left;
  logic [1:0]  tx_phase;
  logic [15:0] phase_ticks;

  rf_remote_frame_transmitter u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Each mismatch prints one line and is counted.
  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Pacing: style 0 never waits, style 1 waits now and then, style 2 always draws.
  function automatic int pace_draw(int style);
    if (style == 0) begin
      return 0;
    end
    if (style == 1 && $urandom_range(0, 7) != 0) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Field values lean on the all-zero and all-one corners.
  function automatic logic [15:0] pick_field(int bits);
    logic [15:0] mask;
    mask = 16'((32'd1 << bits) - 1);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return mask;
      default: return 16'($urandom) & mask;
    endcase
  endfunction

  function automatic void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ZERO_HALF: zero_half = val;
      REG_ONE_HALF:  one_half = val;
      REG_GAP:       gap_len = val;
      REG_REPEAT:    rep_count = val[2:0];
      default: ;
    endcase
  endfunction

  // One more tick in the current phase; true when the phase has run its length.
  function automatic bit phase_over(logic [15:0] len);
    if (phase_ticks != 16'hFFFF) begin
      phase_ticks = phase_ticks + 16'd1;
    end
    if (phase_ticks >= len) begin
      phase_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void close_repeat();
    reps_left = reps_left - 3'd1;
    sym_pos = '0;
    phase_ticks = '0;
    tx_phase = (reps_left == 0) ? PH_IDLE : PH_HIGH;
  endfunction

  // Advance the line predictor by one accepted beat and return its result.
  function automatic rfrt_out_t next_line_state(rfrt_in_t beat);
    rfrt_out_t   r;
    logic [15:0] half;
    logic [7:0]  fb [0:4];
    int          pos;
    r = '0;
    if (beat.command == CMD_START) begin
      if (tx_phase == PH_IDLE) begin
        fb[0] = beat.house_code[15:8];
        fb[1] = beat.house_code[7:0];
        fb[2] = beat.device_address;
        fb[3] = beat.action_code;
        fb[4] = CHECKSUM_SEED + fb[0] + fb[1] + fb[2] + fb[3];
        // Sync zeros stay 0, then the sync one, then each byte MSB first plus parity.
        frame_syms = '0;
        pos = SYNC_ZEROS_DEF;
        frame_syms[pos] = 1'b1;
        pos++;
        for (int k = 0; k < 5; k++) begin
          for (int j = 7; j >= 0; j--) begin
            frame_syms[pos] = fb[k][j];
            pos++;
          end
          frame_syms[pos] = ^fb[k];
          pos++;
        end
        sym_pos = '0;
        phase_ticks = '0;
        reps_left = (rep_count == 0) ? 3'd1 : rep_count;
        tx_phase = PH_HIGH;
        r.start_taken = 1'b1;
      end
      r.busy_res = (tx_phase != PH_IDLE);
      r.pin_level = (tx_phase == PH_HIGH);
    end else begin
      half = frame_syms[sym_pos] ? one_half : zero_half;
      r.busy_res = (tx_phase != PH_IDLE);
      case (tx_phase)
        PH_HIGH: begin
          r.pin_level = 1'b1;
          if (phase_over(half)) begin
            tx_phase = PH_LOW;
          end
        end
        PH_LOW: begin
          if (phase_over(half)) begin
            sym_pos = sym_pos + 6'd1;
            if (sym_pos >= FRAME_SYMS) begin
              if (gap_len == 0) begin
                close_repeat();
              end else begin
                tx_phase = PH_GAP;
              end
            end else begin
              tx_phase = PH_HIGH;
            end
          end
        end
        PH_GAP: begin
          if (phase_over(gap_len)) begin
            close_repeat();
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Feed builders used by the stimulus plan.
  task automatic queue_beat(logic cmd, logic [15:0] hc, logic [7:0] ad, logic [7:0] ac);
    feed_entry_t e;
    e.kind = SEND_BEAT;
    e.beat = '{command: cmd, house_code: hc, device_address: ad, action_code: ac};
    e.reg_index = '0;
    e.reg_value = '0;
    e.gap = pace_draw(tx_style);
    feed_q.push_back(e);
  endtask

  task automatic queue_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    feed_entry_t e;
    e.kind = SEND_REG;
    e.beat = '0;
    e.reg_index = idx;
    e.reg_value = val;
    e.gap = 0;
    feed_q.push_back(e);
  endtask

  task automatic queue_quiet();
    feed_entry_t e;
    e.kind = WAIT_QUIET;
    e.beat = '0;
    e.reg_index = '0;
    e.reg_value = '0;
    e.gap = 0;
    feed_q.push_back(e);
  endtask

  task automatic queue_tick();
    queue_beat(CMD_TICK, pick_field(16), 8'(pick_field(8)), 8'(pick_field(8)));
  endtask

  // Driver: presents beats and register writes from the feed, predicts on acceptance.
  always @(posedge clk) begin : driver
    logic      took_beat;
    logic      took_reg;
    rfrt_out_t fresh;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_data <= '0;
      due_valid <= 1'b0;
      zero_half = ZERO_HALF_RST;
      one_half = ONE_HALF_RST;
      gap_len = GAP_RST;
      rep_count = REPEAT_RST;
      frame_syms = '0;
      sym_pos = '0;
      reps_left = '0;
      tx_phase = PH_IDLE;
      phase_ticks = '0;
    end else begin
      took_beat = in_valid && !in_stall;
      took_reg = cfg_valid && cfg_ready;
      fresh = '0;
      if (took_beat) begin
        fresh = next_line_state(in_data);
        beats_taken++;
      end
      if (took_reg) begin
        write_reg(cfg_index, cfg_data);
      end
      due_valid <= took_beat;
      due_level <= fresh;

      if ((in_valid && !took_beat) || (cfg_valid && !took_reg)) begin
        // A stalled beat or an unfinished write holds its payload.
      end else if (send_idle != 0) begin
        send_idle--;
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (feed_q.size() == 0) begin
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        feed_done <= (results_seen == beats_taken);
      end else begin
        case (feed_q[0].kind)
          SEND_BEAT: begin
            in_valid <= 1'b1;
            in_data <= feed_q[0].beat;
            cfg_valid <= 1'b0;
            send_idle = feed_q[0].gap;
            void'(feed_q.pop_front());
          end
          SEND_REG: begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b1;
            cfg_index <= feed_q[0].reg_index;
            cfg_data <= feed_q[0].reg_value;
            void'(feed_q.pop_front());
          end
          default: begin
            // Hold off until every result of the beats so far has come back.
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
            if (results_seen == beats_taken) begin
              void'(feed_q.pop_front());
            end
          end
        endcase
      end
    end
  end

  // Monitor: takes result beats with random stalls and checks them in order.
  always @(posedge clk) begin : monitor
    rfrt_out_t want;
    int        stall_left;
    int        rx_style;
    int        rx_count;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      rx_style = 0;
      rx_count = 0;
    end else begin
      if (due_valid) begin
        levels_due.push_back(due_level);
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (levels_due.size() == 0) begin
          report_mismatch("result beat with nothing expected", out_data, 0);
        end else begin
          want = levels_due.pop_front();
          if (out_data.pin_level !== want.pin_level) begin
            report_mismatch("pin_level", out_data.pin_level, want.pin_level);
          end
          if (out_data.busy_res !== want.busy_res) begin
            report_mismatch("busy_res", out_data.busy_res, want.busy_res);
          end
          if (out_data.start_taken !== want.start_taken) begin
            report_mismatch("start_taken", out_data.start_taken, want.start_taken);
          end
        end
        rx_count++;
        if (rx_count % 48 == 0) begin
          rx_style = $urandom_range(0, 2);
        end
        stall_left = pace_draw(rx_style);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any accepted beat or write.
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int planned;
    int span;
    logic [15:0] val;

    // Directed: idle ticks, a start at the field maxima under reset settings,
    // a start while busy, then register changes in mid transmission.
    tx_style = 1;
    queue_beat(CMD_TICK, 16'h0000, 8'h00, 8'h00);
    queue_beat(CMD_TICK, 16'hFFFF, 8'hFF, 8'hFF);
    queue_beat(CMD_START, 16'hFFFF, 8'hFF, 8'hFF);
    queue_beat(CMD_START, 16'h0000, 8'h00, 8'h00);
    repeat (5) queue_tick();
    // Longest phases and most repeats while the frame is running.
    queue_quiet();
    queue_reg(REG_ZERO_HALF, 16'hFFFF);
    queue_reg(REG_ONE_HALF, 16'hFFFF);
    queue_reg(REG_GAP, 16'hFFFF);
    queue_reg(REG_REPEAT, 16'hFFFF);
    repeat (4) queue_tick();
    // Zero half period and zero gap: the running phase is already past its
    // new length and must end on the next tick; a zero repeat count acts as one.
    queue_quiet();
    queue_reg(REG_ZERO_HALF, 16'h0000);
    queue_reg(REG_ONE_HALF, 16'h0001);
    queue_reg(REG_GAP, 16'h0000);
    queue_reg(REG_REPEAT, 16'h0000);
    repeat (6) queue_tick();
    queue_beat(CMD_START, 16'h0000, 8'h00, 8'h00);
    repeat (3) queue_tick();

    // Random phases: quiet, a few register writes, then mostly ticks with
    // occasional starts so full frames run end to end.
    planned = 0;
    while (planned < RANDOM_BEATS) begin
      queue_quiet();
      tx_style = $urandom_range(0, 2);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 3))
          0, 1: begin
            case ($urandom_range(0, 15))
              0: val = 16'h0000;
              1: val = 16'hFFFF;
              2: val = 16'($urandom);
              default: val = 16'($urandom_range(1, 3));
            endcase
            queue_reg(($urandom_range(0, 1) == 0) ? REG_ZERO_HALF : REG_ONE_HALF, val);
          end
          2: begin
            case ($urandom_range(0, 15))
              0: val = 16'hFFFF;
              1: val = 16'($urandom);
              2, 3, 4, 5: val = 16'h0000;
              default: val = 16'($urandom_range(1, 8));
            endcase
            queue_reg(REG_GAP, val);
          end
          default: begin
            val = 16'($urandom) & 16'hFFF8;
            if ($urandom_range(0, 3) == 0) begin
              val[2:0] = 3'($urandom_range(0, 7));
            end else begin
              val[2:0] = 3'($urandom_range(1, 2));
            end
            queue_reg(REG_REPEAT, val);
          end
        endcase
      end
      span = $urandom_range(40, 160);
      for (int n = 0; n < span; n++) begin
        if ($urandom_range(0, 39) == 0) begin
          queue_beat(CMD_START, pick_field(16), 8'(pick_field(8)), 8'(pick_field(8)));
        end else begin
          queue_tick();
        end
      end
      planned += span;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (feed_done);
    repeat (10) @(posedge clk);
    if (levels_due.size() != 0) begin
      report_mismatch("results still missing at end", levels_due.size(), 0);
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
